[src/smas_pkg.sv]
`default_nettype none

package smas_pkg;

    // Matrix size and derived storage sizes.
    localparam int DIM       = 3;
    localparam int CELLS     = DIM * DIM;
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LOAD_W    = $clog2(2 * CELLS);

    // Field widths.
    localparam int ELEM_W    = 16;
    localparam int VALUE_W   = 37;
    localparam int IDX_W     = 3;
    localparam int OP_W      = 2;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    // Operation codes of the configuration register.
    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_MUL  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Sequencer states of the compute engine.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } calc_state_t;

    // Start command from the load side to the compute engine.
    typedef struct packed {
        logic go;
        op_t  op;
    } start_t;

    // Read addresses from the compute engine to both stores.
    typedef struct packed {
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
    } rd_req_t;

    // Row-major store address of element (row, col).
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        logic [5:0] flat;
        flat = {3'b000, row} * 6'(DIM) + {3'b000, col};
        return ADDR_W'(flat);
    endfunction

endpackage

`default_nettype wire

[src/smas_ram.sv]
`default_nettype none

module smas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9
) (
    input  wire logic                                       aclk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/smas_calc.sv]
`default_nettype none

module smas_calc (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire smas_pkg::start_t                  start,
    output smas_pkg::rd_req_t                      rd_req,
    input  wire logic [smas_pkg::ELEM_W-1:0]       a_data,
    input  wire logic [smas_pkg::ELEM_W-1:0]       b_data,
    output logic                                   busy,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [smas_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast
);
    import smas_pkg::*;

    calc_state_t state_reg, state_next;
    op_t         op_reg, op_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;

    logic issue, last_k, last_cell, out_free, handover;

    logic rd_vld_reg, rd_last_reg, rd_first_reg;
    logic term_vld_reg, term_last_reg, term_first_reg;
    logic signed [VALUE_W-1:0] term_reg, term_next;
    logic signed [VALUE_W-1:0] acc_reg, acc_next;
    logic done_reg, done_next;

    logic signed [PROD_W-1:0]  prod;
    logic signed [VALUE_W-1:0] a_ext, b_ext;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic [IDX_W-1:0]          m_row_reg, m_col_reg;
    logic                      m_last_reg;

    // Handshake-level conditions of the sequencer.
    assign issue     = (state_reg == ST_ISSUE);
    assign last_k    = (op_reg != OP_MUL) || (k_reg == IDX_W'(DIM - 1));
    assign last_cell = (i_reg == IDX_W'(DIM - 1)) && (j_reg == IDX_W'(DIM - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign handover  = (state_reg == ST_DRAIN) && done_reg && out_free;
    assign busy      = (state_reg != ST_IDLE);

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start.go) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (last_k) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (handover) begin
                    state_next = last_cell ? ST_IDLE : ST_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Counters, operation latch and store read addresses.
    always_comb begin
        op_next = op_reg;
        i_next  = i_reg;
        j_next  = j_reg;
        k_next  = k_reg;
        rd_req.a_addr = cell_addr(i_reg, (op_reg == OP_MUL) ? k_reg : j_reg);
        rd_req.b_addr = (op_reg == OP_MUL) ? cell_addr(k_reg, j_reg) : cell_addr(i_reg, j_reg);
        unique case (state_reg)
            ST_IDLE: begin
                if (start.go) begin
                    op_next = start.op;
                    i_next  = '0;
                    j_next  = '0;
                    k_next  = '0;
                end
            end
            ST_ISSUE: begin
                if (!last_k) begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (handover) begin
                    k_next = '0;
                    if (j_reg == IDX_W'(DIM - 1)) begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Term of the current cell from the two store words.
    assign a_ext = VALUE_W'($signed(a_data));
    assign b_ext = VALUE_W'($signed(b_data));
    assign prod  = $signed(a_data) * $signed(b_data);

    always_comb begin
        unique case (op_reg)
            OP_ADD:  term_next = a_ext + b_ext;
            OP_SUB:  term_next = a_ext - b_ext;
            OP_MUL:  term_next = VALUE_W'(prod);
            OP_NONE: term_next = '0;
            default: term_next = '0;
        endcase
    end

    // Accumulation over the terms of one cell.
    always_comb begin
        acc_next  = acc_reg;
        done_next = done_reg;
        if (term_vld_reg) begin
            acc_next = (term_first_reg ? VALUE_W'(0) : acc_reg) + term_reg;
            if (term_last_reg) begin
                done_next = 1'b1;
            end
        end else if (handover) begin
            done_next = 1'b0;
        end
    end

    // Output register: a finished cell waits here until the beat is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (handover) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            term_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            term_vld_reg <= rd_vld_reg;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Data path registers.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        rd_last_reg    <= last_k;
        rd_first_reg   <= (k_reg == '0);
        term_reg       <= term_next;
        term_last_reg  <= rd_last_reg;
        term_first_reg <= rd_first_reg;
        acc_reg        <= acc_next;
        if (handover) begin
            m_value_reg <= acc_reg;
            m_row_reg   <= i_reg;
            m_col_reg   <= j_reg;
            m_last_reg  <= last_cell;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(M_TDATA_W - VALUE_W - 2 * IDX_W)'(0), m_col_reg, m_row_reg, m_value_reg};

endmodule

`default_nettype wire

[src/small_matrix_add_sub_mul_top.sv]
// DIM x DIM signed matrix add, subtract or multiply (DIM = 3). Send the DIM*DIM
// elements of A and then the DIM*DIM elements of B, row-major, one 16-bit beat
// each; loading takes one cycle per beat while no results are computed. The
// beat that carries the last B element starts a run of DIM*DIM result beats in
// row-major order, each with its 37-bit value, row and column, and tlast on the
// final one. The operation register is sampled on that last B beat. Each result
// cell takes one store read per cycle, then a term stage, an accumulate stage
// and the hand-over into the output register once it is free. No input is
// taken while results are computed; the last result may still wait at the
// output while the next matrices load. Both stores are simple dual-port RAMs
// with registered reads.
`default_nettype none

module small_matrix_add_sub_mul_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [smas_pkg::OP_W-1:0]         cfg_wr_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [15:0] element_value
    input  wire logic [smas_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [36:0] result_value, [39:37] result_row, [42:40] result_col, [47:43] zero
    output logic [smas_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast
);
    import smas_pkg::*;

    op_t               op_reg;
    logic [LOAD_W-1:0] load_cnt_reg, load_cnt_next, b_off;
    logic              in_beat, is_b, load_last, calc_busy;
    start_t            start;
    rd_req_t           rd_req;
    logic [ELEM_W-1:0] a_data, b_data;

    // Input acceptance and store placement.
    assign s_tready  = !calc_busy;
    assign in_beat   = s_tvalid && s_tready;
    assign is_b      = (load_cnt_reg >= LOAD_W'(CELLS));
    assign b_off     = load_cnt_reg - LOAD_W'(CELLS);
    assign load_last = (load_cnt_reg == LOAD_W'(2 * CELLS - 1));
    assign load_cnt_next = load_last ? '0 : load_cnt_reg + 1'b1;

    assign start.go = in_beat && load_last;
    assign start.op = op_reg;

    // Load counter and operation register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg <= '0;
            op_reg       <= OP_ADD;
        end else begin
            if (in_beat) begin
                load_cnt_reg <= load_cnt_next;
            end
            if (cfg_wr_en) begin
                op_reg <= op_t'(cfg_wr_data);
            end
        end
    end

    // Element stores.
    smas_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_a_store (
        .aclk  (aclk),
        .we    (in_beat && !is_b),
        .waddr (load_cnt_reg[ADDR_W-1:0]),
        .wdata (s_tdata[ELEM_W-1:0]),
        .raddr (rd_req.a_addr),
        .rdata (a_data)
    );

    smas_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_b_store (
        .aclk  (aclk),
        .we    (in_beat && is_b),
        .waddr (b_off[ADDR_W-1:0]),
        .wdata (s_tdata[ELEM_W-1:0]),
        .raddr (rd_req.b_addr),
        .rdata (b_data)
    );

    // Compute engine and output register.
    smas_calc u_calc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .rd_req   (rd_req),
        .a_data   (a_data),
        .b_data   (b_data),
        .busy     (calc_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[src/smas_checker.sv]
`default_nettype none

module smas_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [smas_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic                              m_tlast
);
    import smas_pkg::*;

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result beat changed while stalled");

    // The final beat of a run is exactly the bottom-right cell.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == ((m_tdata[39:37] == IDX_W'(DIM - 1)) &&
                                  (m_tdata[42:40] == IDX_W'(DIM - 1)))))
        else $error("tlast does not match the last cell");

    // Row and column stay inside the matrix, padding stays zero.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[39:37] <= IDX_W'(DIM - 1)) &&
                      (m_tdata[42:40] <= IDX_W'(DIM - 1)) &&
                      (m_tdata[47:43] == '0)))
        else $error("result index out of range");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind small_matrix_add_sub_mul_top smas_checker u_smas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[dv/small_matrix_add_sub_mul_top_tb.sv]
`default_nettype none

module small_matrix_add_sub_mul_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smas_pkg::*;

    localparam int IDLE_PCT    = 29;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RUN_CYCLES  = CELLS * (DIM + 3) + 20;

    // One result element as it should appear on the master side.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic               last;
    } cell_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [OP_W-1:0]       cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    // Elements waiting to be sent and result cells waiting to arrive.
    logic [ELEM_W-1:0]     element_queue[$];
    cell_t                 expected_cells[$];

    // Own copy of the block's stores, load position and operation.
    logic signed [ELEM_W-1:0] a_cells[CELLS];
    logic signed [ELEM_W-1:0] b_cells[CELLS];
    int unsigned           loaded;
    op_t                   cur_op;

    int unsigned           errors = 0;
    int unsigned           cycles = 0;
    logic                  steady = 1'b0;

    small_matrix_add_sub_mul_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Value of cell (r, c) under the current operation, exact at 37 bits.
    function automatic logic signed [VALUE_W-1:0] matrix_cell(int r, int c);
        logic signed [VALUE_W-1:0] acc;
        acc = '0;
        case (cur_op)
            OP_ADD: begin
                acc = a_cells[r * DIM + c];
                acc = acc + b_cells[r * DIM + c];
            end
            OP_SUB: begin
                acc = a_cells[r * DIM + c];
                acc = acc - b_cells[r * DIM + c];
            end
            OP_MUL: begin
                for (int k = 0; k < DIM; k++)
                    acc = acc + a_cells[r * DIM + k] * b_cells[k * DIM + c];
            end
            default: acc = '0;
        endcase
        return acc;
    endfunction

    // Source: hold a beat until accepted, then maybe offer the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (element_queue.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= element_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: random backpressure except during the steady stretch.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Predictor and checker, both sampled at the same edge.
    always @(posedge aclk) begin
        cell_t want;
        cell_t got;
        logic signed [ELEM_W-1:0] elem;
        if (!aresetn) begin
            loaded = 0;
            cur_op = OP_ADD;
        end else begin
            if (cfg_wr_en)
                cur_op = op_t'(cfg_wr_data);

            // Accepted input beat: place it, and emit the run on the last B beat.
            if (s_tvalid && s_tready) begin
                elem = s_tdata[ELEM_W-1:0];
                if (loaded < CELLS) begin
                    a_cells[loaded] = elem;
                    loaded++;
                end else begin
                    b_cells[loaded - CELLS] = elem;
                    loaded++;
                    if (loaded == 2 * CELLS) begin
                        loaded = 0;
                        for (int r = 0; r < DIM; r++) begin
                            for (int c = 0; c < DIM; c++) begin
                                want.value = matrix_cell(r, c);
                                want.row   = IDX_W'(r);
                                want.col   = IDX_W'(c);
                                want.last  = (r == DIM - 1) && (c == DIM - 1);
                                expected_cells.push_back(want);
                            end
                        end
                    end
                end
            end

            // Accepted result beat: compare against the oldest expectation.
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[VALUE_W-1:0];
                got.row   = m_tdata[VALUE_W+IDX_W-1:VALUE_W];
                got.col   = m_tdata[VALUE_W+2*IDX_W-1:VALUE_W+IDX_W];
                got.last  = m_tlast;
                if (expected_cells.size() == 0) begin
                    $error("unexpected result beat: value %0h row %0d col %0d",
                           got.value, got.row, got.col);
                    errors++;
                end else begin
                    want = expected_cells.pop_front();
                    if (got.value !== want.value) begin
                        $error("result_value: expected %0h, got %0h", want.value, got.value);
                        errors++;
                    end
                    if (got.row !== want.row) begin
                        $error("result_row: expected %0d, got %0d", want.row, got.row);
                        errors++;
                    end
                    if (got.col !== want.col) begin
                        $error("result_col: expected %0d, got %0d", want.col, got.col);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Random element, weighted toward the extremes and small magnitudes.
    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return ELEM_W'($urandom_range(0, 15)) - 16'd8;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Wait until the source is empty and every expected cell has arrived,
    // then let a full compute run's worth of cycles pass.
    task automatic wait_idle();
        do @(negedge aclk);
        while (element_queue.size() != 0 || s_tvalid || expected_cells.size() != 0);
        repeat (RUN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_operation(op_t op);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= op;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // Stimulus sequence.
    initial begin
        op_t phase_ops[9];
        logic [ELEM_W-1:0] a_edge[CELLS];
        logic [ELEM_W-1:0] b_edge[CELLS];
        int pairs;

        phase_ops = '{OP_MUL, OP_ADD, OP_SUB, OP_MUL, OP_NONE,
                      OP_ADD, OP_MUL, OP_SUB, OP_MUL};
        a_edge = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                   16'h0000, 16'hffff, 16'h0001};
        b_edge = '{16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff, 16'hffff,
                   16'h8000, 16'h7fff, 16'h0001};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed pair: the largest products of both signs, zero and minus one.
        write_operation(phase_ops[0]);
        foreach (a_edge[i]) element_queue.push_back(a_edge[i]);
        foreach (b_edge[i]) element_queue.push_back(b_edge[i]);

        // Random phases, one operation each, written only when idle.
        for (int p = 1; p < 9; p++) begin
            wait_idle();
            write_operation(phase_ops[p]);
            steady = (p == 3);
            pairs = (p == 3) ? 4 : 3;
            for (int n = 0; n < pairs * 2 * CELLS; n++)
                element_queue.push_back(random_element());
        end

        wait_idle();
        steady = 1'b0;
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
